// ===== sv/hcbd_pkg.sv =====
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types, character codes and hex digit decode for the chunked body
// decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

    // Decoder phase
    typedef enum logic [2:0] {
        PH_SIZE,
        PH_EXT,
        PH_SIZE_LF,
        PH_DATA,
        PH_DATA_CR,
        PH_DATA_LF,
        PH_DONE,
        PH_ERROR
    } t_phase;

    // Status codes shown on o_status
    typedef enum logic [1:0] {
        ST_OK,
        ST_EMPTY_SIZE,
        ST_MISSING_CRLF,
        ST_OVERFLOW
    } t_status;

    // Result of a hex digit decode
    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } t_hex;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // Decode one ASCII hex digit, either case
    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.is_hex = 1'b0;
        h.value  = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.is_hex = 1'b1;
            h.value  = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            h.is_hex = 1'b1;
            h.value  = c[3:0] + 4'd9;
        end
        return h;
    endfunction

endpackage

// ===== sv/http_chunked_body_decoder.sv =====
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Decodes an HTTP/1.1 chunked body one byte per beat into payload bytes,
// an end-of-body flag and an error status.
// ----------------------------------------------------------------------------
// Each accepted input beat yields exactly one result beat, through the input
// register and then the result register. One byte is taken every cycle while
// the output is not stalled: the next phase, size accumulator and
// remaining-byte counter are computed combinationally between the input
// register and the result register, and that per-byte phase loop sets the
// rate. A SIZE_BITS-wide decrement and zero compare of the remaining-byte
// count is the longest path. After the zero-size chunk or after an error the
// decoder ignores input until reset, and the result beats repeat the final body_end and status values.
module http_chunked_body_decoder
    import hcbd_pkg::*;
#(
    parameter int SIZE_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_data_byte,
    output logic       o_data_valid,
    output logic       o_body_end,
    output logic [1:0] o_status
);

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // Decoder state
    t_phase                r_phase, n_phase;
    logic [SIZE_BITS-1:0]  r_size, n_size;
    logic                  r_digit_seen, n_digit_seen;
    logic [SIZE_BITS-1:0]  r_bytes_left, n_bytes_left;
    t_status               r_err, n_err;

    // Result register
    logic       r_out_valid;
    logic [7:0] r_data_byte, n_data_byte;
    logic       r_data_valid, n_data_valid;
    logic       r_body_end, n_body_end;
    t_status    r_status, n_status;

    logic                 out_ready;
    logic                 advance;
    t_hex                 hex;
    logic [SIZE_BITS-1:0] left_dec;

    // Handshake: the result register frees when taken, the input register
    // moves when the result register can load
    assign out_ready = !r_out_valid || !i_stall;
    assign advance   = r_in_valid && out_ready;
    assign o_stall   = r_in_valid && !out_ready;

    assign hex      = hex_decode(r_in_byte);
    assign left_dec = r_bytes_left - SIZE_BITS'(1);

    // Next state of the decoder for the byte in the input register
    always_comb begin
        n_phase      = r_phase;
        n_size       = r_size;
        n_digit_seen = r_digit_seen;
        n_bytes_left = r_bytes_left;
        n_err        = r_err;
        case (r_phase)
            PH_SIZE: begin
                if (r_in_byte == CH_CR) begin
                    if (!r_digit_seen) begin
                        n_phase = PH_ERROR;
                        n_err   = ST_EMPTY_SIZE;
                    end else begin
                        n_phase = PH_SIZE_LF;
                    end
                end else if (!hex.is_hex) begin
                    n_phase = PH_EXT;
                end else if (|r_size[SIZE_BITS-1 -: 4]) begin
                    n_phase = PH_ERROR;
                    n_err   = ST_OVERFLOW;
                end else begin
                    n_size       = {r_size[SIZE_BITS-5:0], hex.value};
                    n_digit_seen = 1'b1;
                end
            end
            PH_EXT: begin
                if (r_in_byte == CH_CR) begin
                    if (!r_digit_seen) begin
                        n_phase = PH_ERROR;
                        n_err   = ST_EMPTY_SIZE;
                    end else begin
                        n_phase = PH_SIZE_LF;
                    end
                end
            end
            PH_SIZE_LF: begin
                if (r_in_byte != CH_LF) begin
                    n_phase = PH_ERROR;
                    n_err   = ST_MISSING_CRLF;
                end else if (r_size == '0) begin
                    n_phase = PH_DONE;
                end else begin
                    n_bytes_left = r_size;
                    n_phase      = PH_DATA;
                end
            end
            PH_DATA: begin
                n_bytes_left = left_dec;
                if (left_dec == '0) begin
                    n_phase = PH_DATA_CR;
                end
            end
            PH_DATA_CR: begin
                if (r_in_byte != CH_CR) begin
                    n_phase = PH_ERROR;
                    n_err   = ST_MISSING_CRLF;
                end else begin
                    n_phase = PH_DATA_LF;
                end
            end
            PH_DATA_LF: begin
                if (r_in_byte != CH_LF) begin
                    n_phase = PH_ERROR;
                    n_err   = ST_MISSING_CRLF;
                end else begin
                    n_phase      = PH_SIZE;
                    n_size       = '0;
                    n_digit_seen = 1'b0;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    // Result fields for the byte in the input register
    always_comb begin
        n_data_valid = (r_phase == PH_DATA);
        n_data_byte  = n_data_valid ? r_in_byte : 8'd0;
        n_body_end   = (n_phase == PH_DONE);
        n_status     = (n_phase == PH_ERROR) ? n_err : ST_OK;
    end

    // Load the input register when it is empty or moving on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
        if (!o_stall && i_valid) begin
            r_in_byte <= i_in_byte;
        end
    end

    // Advance the decoder state on each byte that moves to the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SIZE;
            r_size       <= '0;
            r_digit_seen <= 1'b0;
            r_bytes_left <= '0;
            r_err        <= ST_OK;
        end else if (advance) begin
            r_phase      <= n_phase;
            r_size       <= n_size;
            r_digit_seen <= n_digit_seen;
            r_bytes_left <= n_bytes_left;
            r_err        <= n_err;
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_in_valid;
        end
        if (advance) begin
            r_data_byte  <= n_data_byte;
            r_data_valid <= n_data_valid;
            r_body_end   <= n_body_end;
            r_status     <= n_status;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_data_byte  = r_data_byte;
    assign o_data_valid = r_data_valid;
    assign o_body_end   = r_body_end;
    assign o_status     = r_status;

    // Payload beats carry no end or error flag
    a_data_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data_valid) |-> (!o_body_end && o_status == ST_OK))
        else $error("payload beat with end or error flag");

    // End of body and error never show together
    a_end_or_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_body_end && o_status != ST_OK))
        else $error("body end together with error status");

    // The data phase always has bytes left to pass
    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_bytes_left != '0))
        else $error("data phase with zero bytes left");

    // Error and done are final until reset
    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ERROR) |=> (r_phase == PH_ERROR))
        else $error("left error phase without reset");

    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE) |=> (r_phase == PH_DONE))
        else $error("left done phase without reset");

    // Stall only while a byte waits in the input register
    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid && i_stall))
        else $error("input stalled without a waiting byte");

endmodule
